// ----- rtl/core/swm_pkg.sv -----
// Shared constants, types and state codes of the sliding window maximum core.
package swm_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned MaxWindow = 64;
  localparam int unsigned WinW      = 7;
  localparam int unsigned PtrW      = $clog2(MaxWindow);
  localparam int unsigned OccW      = $clog2(MaxWindow + 1);
  localparam int unsigned PosW      = $clog2(2 * MaxWindow);
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam int unsigned AddrW     = 3;
  localparam int unsigned BusW      = 32;

  localparam logic [AddrW-1:0] RegWindowLen = AddrW'(0);

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    last;
    logic [WinW-1:0]         win;
  } item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         pos;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    StIdle,
    StFront,
    StBack,
    StAppend
  } state_e;

endpackage

// ----- rtl/core/sliding_window_maximum_core.sv -----
// Top level of the sliding window maximum core: config register, front, queue and back.
//
//   channel   direction  handshake                  payload
//   input     in         push / full                sample_i, last_in_stream_i
//   result    out        pop / empty                window_max_o, result_last_o
//   config    in         psel/penable/pwrite/pready window_len at byte address 0
//
// A word into an empty deque goes from idle straight to append; otherwise the front and
// back states first drop expired and smaller entries one at a time, as set by the
// single read port of the entry RAM. The append also waits while the result register
// still holds an unpopped word.
// Reset clears pointers, counters and the window length (to 1); the entry RAM needs no
// clearing pass. A four-word queue decouples input from the deque engine, and the
// result register lets the engine run on while a word waits to be popped.
module sliding_window_maximum_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic signed [swm_pkg::DataW-1:0] sample_i,
  input  logic                             last_in_stream_i,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic signed [swm_pkg::DataW-1:0] window_max_o,
  output logic                             result_last_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [swm_pkg::AddrW-1:0]        paddr,
  input  logic [swm_pkg::BusW-1:0]         pwdata,
  output logic [swm_pkg::BusW-1:0]         prdata,
  output logic                             pready
);

  logic [swm_pkg::WinW-1:0] window_len_q;
  logic                     q_push, q_pop;
  swm_pkg::item_t           q_in, q_out;
  swm_pkg::q_status_t       q_status;

  assign pready = 1'b1;
  assign prdata = (paddr == swm_pkg::RegWindowLen)
                  ? swm_pkg::BusW'(window_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= swm_pkg::WinW'(1);
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      window_len_q <= pwdata[swm_pkg::WinW-1:0];
    end
  end

  swm_front u_front (
    .push_i,
    .sample_i,
    .last_in_stream_i,
    .window_len_i(window_len_q),
    .q_status_i  (q_status),
    .full_o,
    .q_push_o    (q_push),
    .q_data_o    (q_in)
  );

  swm_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .status_o(q_status)
  );

  swm_back u_back (
    .clk_i,
    .rst_ni,
    .q_status_i(q_status),
    .q_data_i  (q_out),
    .q_pop_o   (q_pop),
    .empty_o,
    .pop_i,
    .window_max_o,
    .result_last_o
  );

endmodule

// ----- rtl/core/swm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module swm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- rtl/core/swm_fifo.sv -----
// Short word queue between the front and back parts.
module swm_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  swm_pkg::item_t    data_i,
  input  logic              pop_i,
  output swm_pkg::item_t    data_o,
  output swm_pkg::q_status_t status_o
);

  swm_pkg::item_t                  slot_q [swm_pkg::QDepth];
  logic [swm_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [swm_pkg::QCntW-1:0]       cnt_q;
  logic                            do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == swm_pkg::QCntW'(swm_pkg::QDepth));
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign data_o         = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/swm_front.sv -----
// Front part: takes input words and tags each with its effective window length.
module swm_front (
  input  logic                            push_i,
  input  logic signed [swm_pkg::DataW-1:0] sample_i,
  input  logic                            last_in_stream_i,
  input  logic [swm_pkg::WinW-1:0]        window_len_i,
  input  swm_pkg::q_status_t              q_status_i,
  output logic                            full_o,
  output logic                            q_push_o,
  output swm_pkg::item_t                  q_data_o
);

  logic [swm_pkg::WinW-1:0] win_eff;

  // clamp the window into 1..MaxWindow
  always_comb begin
    if (window_len_i == '0) begin
      win_eff = swm_pkg::WinW'(1);
    end else if (window_len_i > swm_pkg::WinW'(swm_pkg::MaxWindow)) begin
      win_eff = swm_pkg::WinW'(swm_pkg::MaxWindow);
    end else begin
      win_eff = window_len_i;
    end
  end

  assign full_o          = q_status_i.full;
  assign q_push_o        = push_i & ~q_status_i.full;
  assign q_data_o.sample = sample_i;
  assign q_data_o.last   = last_in_stream_i;
  assign q_data_o.win    = win_eff;

endmodule

// ----- rtl/core/swm_back.sv -----
// Back part: runs the monotonic deque over the entry RAM and holds the result.
module swm_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  swm_pkg::q_status_t               q_status_i,
  input  swm_pkg::item_t                   q_data_i,
  output logic                             q_pop_o,
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic signed [swm_pkg::DataW-1:0] window_max_o,
  output logic                             result_last_o
);

  swm_pkg::state_e               state_q, state_d;
  logic [swm_pkg::PtrW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [swm_pkg::OccW-1:0]      occ_q, occ_d, fill_q, fill_d, fill_inc;
  logic [swm_pkg::PosW-1:0]      pos_q, pos_d, age;
  swm_pkg::item_t                cur_q, cur_d;
  logic signed [swm_pkg::DataW-1:0] head_val_q, head_val_d;
  logic                          res_valid_q, res_valid_d;
  logic signed [swm_pkg::DataW-1:0] res_value_q, res_value_d;
  logic                          res_last_q, res_last_d;

  logic                          rd_en, wr_en;
  logic [swm_pkg::PtrW-1:0]      rd_addr;
  logic [$bits(swm_pkg::entry_t)-1:0] rd_raw;
  swm_pkg::entry_t               rd_ent, wr_ent;

  swm_ram #(
    .Width($bits(swm_pkg::entry_t)),
    .Depth(swm_pkg::MaxWindow)
  ) u_entry_ram (
    .clk_i,
    .wr_en_i  (wr_en),
    .wr_addr_i(tail_q),
    .wr_data_i(wr_ent),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_raw)
  );

  assign rd_ent        = rd_raw;
  assign age           = pos_q - rd_ent.pos;
  assign fill_inc      = (fill_q == swm_pkg::OccW'(swm_pkg::MaxWindow)) ? fill_q
                                                                        : fill_q + 1'b1;
  assign wr_ent.value  = cur_q.sample;
  assign wr_ent.pos    = pos_q;
  assign empty_o       = ~res_valid_q;
  assign window_max_o  = res_value_q;
  assign result_last_o = res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swm_pkg::StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    head_val_q  <= head_val_d;
    res_value_q <= res_value_d;
    res_last_q  <= res_last_d;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    cur_d       = cur_q;
    head_val_d  = head_val_q;
    res_valid_d = res_valid_q & ~pop_i;
    res_value_d = res_value_q;
    res_last_d  = res_last_q;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    wr_en       = 1'b0;

    case (state_q)
      swm_pkg::StIdle: begin
        if (!q_status_i.empty) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = (occ_q != '0) ? swm_pkg::StFront : swm_pkg::StAppend;
        end
      end

      swm_pkg::StFront: begin
        if (age >= swm_pkg::PosW'(cur_q.win)) begin
          // drop the expired front word
          head_d = head_q + 1'b1;
          occ_d  = occ_q - 1'b1;
          if (occ_q == swm_pkg::OccW'(1)) begin
            state_d = swm_pkg::StAppend;
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_q + 1'b1;
          end
        end else begin
          head_val_d = rd_ent.value;
          rd_en      = 1'b1;
          rd_addr    = tail_q - 1'b1;
          state_d    = swm_pkg::StBack;
        end
      end

      swm_pkg::StBack: begin
        if (rd_ent.value < cur_q.sample) begin
          // drop the smaller back word
          tail_d = tail_q - 1'b1;
          occ_d  = occ_q - 1'b1;
          if (occ_q == swm_pkg::OccW'(1)) begin
            state_d = swm_pkg::StAppend;
          end else begin
            rd_en   = 1'b1;
            rd_addr = tail_q - 2'd2;
          end
        end else begin
          state_d = swm_pkg::StAppend;
        end
      end

      swm_pkg::StAppend: begin
        // hold until the result register is free
        if (!res_valid_q || pop_i) begin
          wr_en = 1'b1;
          if (fill_inc >= swm_pkg::OccW'(cur_q.win)) begin
            res_valid_d = 1'b1;
            res_value_d = (occ_q == '0) ? cur_q.sample : head_val_q;
            res_last_d  = cur_q.last;
          end
          if (cur_q.last) begin
            head_d = '0;
            tail_d = '0;
            occ_d  = '0;
            pos_d  = '0;
            fill_d = '0;
          end else begin
            tail_d = tail_q + 1'b1;
            occ_d  = occ_q + 1'b1;
            pos_d  = pos_q + 1'b1;
            fill_d = fill_inc;
          end
          state_d = swm_pkg::StIdle;
        end
      end

      default: state_d = swm_pkg::StIdle;
    endcase
  end

endmodule
